>>> rtl/nce_pkg.sv
// Package for the nonzero coordinate extractor: sizes, register indexes,
// element kind codes and the item types passed between the front, queue and back.
// No dependencies.
`default_nettype none

package nce_pkg;

    // Axis limits: the hardware has four coordinate ports; MAX_AXES caps the
    // number of axes that the coordinate counter tracks.
    localparam int MAX_AXES = 4;
    localparam int HW_AXES  = 4;
    localparam int AXES_LIM = (MAX_AXES < HW_AXES) ? MAX_AXES : HW_AXES;

    localparam int COORD_W = 16;
    localparam int COUNT_W = 32;
    localparam int ELEM_W  = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int KIND_W  = 3;
    localparam int AXCNT_W = 3;

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_KIND = 3'd5;

    // Element kind codes.
    localparam logic [KIND_W-1:0] KIND_INT8    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INT32   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INT64   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FLOAT32 = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FLOAT64 = 3'd4;

    // Result kind codes.
    localparam logic RESULT_COORD = 1'b0;
    localparam logic RESULT_COUNT = 1'b1;

    // One classified item: what results it causes and their payload.
    typedef struct packed {
        logic                             has_coord;
        logic                             has_count;
        logic [HW_AXES-1:0][COORD_W-1:0]  coord;
        logic [COUNT_W-1:0]               count;
    } entry_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic nonempty;
    } q_status_t;

endpackage

`default_nettype wire

>>> rtl/nce_front.sv
// Front part: configuration registers, zero test, coordinate counter and
// running count. Depends on nce_pkg.
`default_nettype none

module nce_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [nce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nce_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             accept,
    input  wire logic [nce_pkg::ELEM_W-1:0]       element_bits,
    output nce_pkg::entry_t                       entry,
    output logic                                  entry_push
);

    logic [nce_pkg::AXCNT_W-1:0]  axis_count_reg;
    logic [nce_pkg::KIND_W-1:0]   element_kind_reg;
    logic [nce_pkg::HW_AXES-1:0][nce_pkg::COORD_W-1:0] size_reg;

    logic [nce_pkg::AXES_LIM-1:0][nce_pkg::COORD_W-1:0] pos_reg;
    logic [nce_pkg::AXES_LIM-1:0][nce_pkg::COORD_W-1:0] pos_next;
    logic [nce_pkg::COUNT_W-1:0]  count_reg;
    logic [nce_pkg::COUNT_W-1:0]  count_inc;

    logic [nce_pkg::AXCNT_W-1:0]  used_n;
    logic [nce_pkg::AXES_LIM-1:0] at_end;
    logic                         nz;
    logic                         last;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_count_reg   <= nce_pkg::AXCNT_W'(1);
            element_kind_reg <= nce_pkg::KIND_INT64;
            for (int i = 0; i < nce_pkg::HW_AXES; i++)
            begin
                size_reg[i] <= nce_pkg::COORD_W'(1);
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                nce_pkg::REG_AXIS_COUNT:   axis_count_reg <= cfg_data[nce_pkg::AXCNT_W-1:0];
                nce_pkg::REG_SIZE_AXIS0:   size_reg[0] <= cfg_data;
                nce_pkg::REG_SIZE_AXIS1:   size_reg[1] <= cfg_data;
                nce_pkg::REG_SIZE_AXIS2:   size_reg[2] <= cfg_data;
                nce_pkg::REG_SIZE_AXIS3:   size_reg[3] <= cfg_data;
                nce_pkg::REG_ELEMENT_KIND: element_kind_reg <= cfg_data[nce_pkg::KIND_W-1:0];
                default: ;
            endcase
        end
    end

    // Number of axes in use, clamped into range.
    always_comb
    begin
        if (axis_count_reg == '0)
        begin
            used_n = nce_pkg::AXCNT_W'(1);
        end
        else if (axis_count_reg > nce_pkg::AXCNT_W'(nce_pkg::AXES_LIM))
        begin
            used_n = nce_pkg::AXCNT_W'(nce_pkg::AXES_LIM);
        end
        else
        begin
            used_n = axis_count_reg;
        end
    end

    // Zero test; the float kinds ignore the sign bit.
    always_comb
    begin
        case (element_kind_reg)
            nce_pkg::KIND_INT8:    nz = (element_bits[7:0] != '0);
            nce_pkg::KIND_INT32:   nz = (element_bits[31:0] != '0);
            nce_pkg::KIND_FLOAT32: nz = (element_bits[30:0] != '0);
            nce_pkg::KIND_FLOAT64: nz = (element_bits[62:0] != '0);
            default:               nz = (element_bits != '0);
        endcase
    end

    // An axis is at its end when position + 1 reaches its extent; a zero
    // extent counts as one.
    always_comb
    begin
        logic [nce_pkg::COORD_W:0] ext;
        for (int a = 0; a < nce_pkg::AXES_LIM; a++)
        begin
            ext = (size_reg[a] == '0) ? (nce_pkg::COORD_W+1)'(1) : {1'b0, size_reg[a]};
            at_end[a] = (({1'b0, pos_reg[a]} + (nce_pkg::COORD_W+1)'(1)) >= ext);
        end
    end

    // Final element of the tensor and the odometer step.
    always_comb
    begin
        logic carry;
        last  = 1'b1;
        carry = 1'b1;
        pos_next = pos_reg;
        for (int a = 0; a < nce_pkg::AXES_LIM; a++)
        begin
            if ((nce_pkg::AXCNT_W'(a) < used_n) && !at_end[a])
            begin
                last = 1'b0;
            end
        end
        for (int a = nce_pkg::AXES_LIM - 1; a >= 0; a--)
        begin
            if ((nce_pkg::AXCNT_W'(a) < used_n) && carry)
            begin
                if (at_end[a])
                begin
                    pos_next[a] = '0;
                end
                else
                begin
                    pos_next[a] = pos_reg[a] + nce_pkg::COORD_W'(1);
                    carry = 1'b0;
                end
            end
        end
    end

    assign count_inc = (nz && (count_reg != '1)) ? count_reg + nce_pkg::COUNT_W'(1)
                                                 : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                pos_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                count_reg <= count_inc;
            end
        end
    end

    // Classified item toward the queue; unused axes read as zero.
    always_comb
    begin
        entry.has_coord = nz;
        entry.has_count = last;
        entry.count     = count_inc;
        entry.coord     = '0;
        for (int a = 0; a < nce_pkg::AXES_LIM; a++)
        begin
            if (nce_pkg::AXCNT_W'(a) < used_n)
            begin
                entry.coord[a] = pos_reg[a];
            end
        end
    end

    assign entry_push = accept && (nz || last);

endmodule

`default_nettype wire

>>> rtl/nce_queue.sv
// Short queue of classified items between the front and the back.
// Depends on nce_pkg.
`default_nettype none

module nce_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire nce_pkg::entry_t   push_entry,
    input  wire logic              deq,
    output nce_pkg::entry_t        head_entry,
    output nce_pkg::q_status_t     status
);

    nce_pkg::entry_t              mem_reg [nce_pkg::QDEPTH];
    logic [nce_pkg::QPTR_W-1:0]   wptr_reg;
    logic [nce_pkg::QPTR_W-1:0]   rptr_reg;
    logic [nce_pkg::QCNT_W-1:0]   cnt_reg;
    logic                         do_push;
    logic                         do_deq;

    assign status.full     = (cnt_reg == nce_pkg::QCNT_W'(nce_pkg::QDEPTH));
    assign status.nonempty = (cnt_reg != '0);
    assign do_push = push && !status.full;
    assign do_deq  = deq && status.nonempty;
    assign head_entry = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == nce_pkg::QPTR_W'(nce_pkg::QDEPTH - 1))
                            ? '0 : wptr_reg + nce_pkg::QPTR_W'(1);
            end
            if (do_deq)
            begin
                rptr_reg <= (rptr_reg == nce_pkg::QPTR_W'(nce_pkg::QDEPTH - 1))
                            ? '0 : rptr_reg + nce_pkg::QPTR_W'(1);
            end
            case ({do_push, do_deq})
                2'b10:   cnt_reg <= cnt_reg + nce_pkg::QCNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - nce_pkg::QCNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/nce_back.sv
// Back part: expands each queued item into its one or two results and holds
// the oldest result in an output register. Depends on nce_pkg.
`default_nettype none

module nce_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire nce_pkg::q_status_t                q_status,
    input  wire nce_pkg::entry_t                   head_entry,
    output logic                                   deq,
    input  wire logic                              pop,
    output logic                                   out_valid,
    output logic                                   result_kind,
    output logic [nce_pkg::HW_AXES-1:0][nce_pkg::COORD_W-1:0] coord,
    output logic [nce_pkg::COUNT_W-1:0]            nonzero_count,
    output logic                                   last_of_run
);

    logic out_valid_reg;
    logic phase_reg;
    logic load;
    logic emit_coord;
    logic kind_reg;
    logic last_reg;
    logic [nce_pkg::HW_AXES-1:0][nce_pkg::COORD_W-1:0] coord_reg;
    logic [nce_pkg::COUNT_W-1:0] count_reg;

    // phase_reg is set once the coordinate result of a two-result item has gone out.
    assign load       = q_status.nonempty && (!out_valid_reg || pop);
    assign emit_coord = head_entry.has_coord && !phase_reg;
    assign deq        = load && (!emit_coord || !head_entry.has_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            phase_reg     <= emit_coord && head_entry.has_count;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= emit_coord ? nce_pkg::RESULT_COORD : nce_pkg::RESULT_COUNT;
            coord_reg <= emit_coord ? head_entry.coord : '0;
            count_reg <= head_entry.count;
            last_reg  <= emit_coord ? !head_entry.has_count : 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign coord         = coord_reg;
    assign nonzero_count = count_reg;
    assign last_of_run   = last_reg;

endmodule

`default_nettype wire

>>> rtl/nonzero_coordinate_extractor_top.sv
// Top level of the nonzero coordinate extractor: front, queue and back.
// Depends on nce_pkg, nce_front, nce_queue and nce_back.
//
//   Channel   Handshake          Payload
//   input     push / full        element_bits
//   result    empty / pop        result_kind, coord0..coord3, nonzero_count, last_of_run
//   config    cfg_write          cfg_index, cfg_data
//
// The front takes one item per cycle while the four-entry queue has room; the
// coordinate counter and running count update in the cycle of acceptance.
// The back sends one result per cycle from its output register unless pop stalls,
// so a nonzero item at the end of a tensor yields a coordinate and then a count result.
// Reset (rst_n low, asynchronous) restores the register defaults, clears the
// counter, the count and the queue. full rises only when the queue is full;
// a stalled pop holds the result on the ports.
`default_nettype none

module nonzero_coordinate_extractor_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [nce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [nce_pkg::ELEM_W-1:0]      element_bits,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic                                 result_kind,
    output logic [nce_pkg::COORD_W-1:0]          coord0,
    output logic [nce_pkg::COORD_W-1:0]          coord1,
    output logic [nce_pkg::COORD_W-1:0]          coord2,
    output logic [nce_pkg::COORD_W-1:0]          coord3,
    output logic [nce_pkg::COUNT_W-1:0]          nonzero_count,
    output logic                                 last_of_run
);

    nce_pkg::entry_t     push_entry;
    nce_pkg::entry_t     head_entry;
    nce_pkg::q_status_t  q_status;
    logic                entry_push;
    logic                deq;
    logic                accept;
    logic                out_valid;
    logic [nce_pkg::HW_AXES-1:0][nce_pkg::COORD_W-1:0] coord;

    // An item is taken whenever the queue has room, even if it causes no result.
    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    nce_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .element_bits (element_bits),
        .entry        (push_entry),
        .entry_push   (entry_push)
    );

    nce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (entry_push),
        .push_entry (push_entry),
        .deq        (deq),
        .head_entry (head_entry),
        .status     (q_status)
    );

    nce_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head_entry    (head_entry),
        .deq           (deq),
        .pop           (pop),
        .out_valid     (out_valid),
        .result_kind   (result_kind),
        .coord         (coord),
        .nonzero_count (nonzero_count),
        .last_of_run   (last_of_run)
    );

    assign empty  = !out_valid;
    assign coord0 = coord[0];
    assign coord1 = coord[1];
    assign coord2 = coord[2];
    assign coord3 = coord[3];

endmodule

`default_nettype wire
